### design/prf_pkg.sv
// Shared types and constants for the page record framer.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
package prf_pkg;

   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 6;
   localparam int ADDR_W   = 16;

   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;
   localparam logic [BYTE_W-1:0] CHECK_XOR   = 8'h51;

   // Which page byte the datapath loads into the output register.
   localparam logic [2:0] KIND_HDR  = 3'd0;
   localparam logic [2:0] KIND_DATA = 3'd1;
   localparam logic [2:0] KIND_PAD  = 3'd2;
   localparam logic [2:0] KIND_CHK  = 3'd3;
   localparam logic [2:0] KIND_FCHK = 3'd4;

   typedef struct packed {
      logic       take;
      logic       emit;
      logic [2:0] kind;
      logic       run_last;
   } prf_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_holds;
      logic req_last;
      logic item_holds;
      logic item_last;
      logic fill_zero;
      logic fill_next_full;
      logic out_free;
   } prf_status_type;

endpackage

### design/prf_req_if.sv
// Input channel of the page record framer: valid/ready plus one record beat.
// Depends on prf_pkg.
interface prf_req_if;
   import prf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              holds_byte;
   logic              is_last;

   modport source (output valid, output data_byte, output holds_byte, output is_last,
                   input ready);
   modport sink   (input valid, input data_byte, input holds_byte, input is_last,
                   output ready);
endinterface

### design/prf_rsp_if.sv
// Result channel of the page record framer: valid/ready plus one framed page byte.
// Depends on prf_pkg.
interface prf_rsp_if;
   import prf_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic [OFFSET_W-1:0] byte_offset;
   logic [ADDR_W-1:0]   page_address;
   logic                page_end;
   logic                record_end;
   logic                run_last;

   modport source (output valid, output out_byte, output byte_offset, output page_address,
                   output page_end, output record_end, output run_last, input ready);
   modport sink   (input valid, input out_byte, input byte_offset, input page_address,
                   input page_end, input record_end, input run_last, output ready);
endinterface

### design/prf_ctrl.sv
// Sequencer of the page record framer: steps through header, data, padding and
// check beats for one accepted item. Depends on prf_pkg.
module prf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  prf_pkg::prf_status_type status,
   output prf_pkg::prf_cmd_type    cmd
);
   import prf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HDR  = 3'd1;
   localparam logic [2:0] ST_DATA = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_PAD  = 3'd4;
   localparam logic [2:0] ST_FCHK = 3'd5;
   localparam logic [2:0] ST_PHDR = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.take     = 1'b0;
      cmd.emit     = 1'b0;
      cmd.kind     = KIND_HDR;
      cmd.run_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.req_valid && (status.req_holds || status.req_last)) begin
               if (status.fill_zero)
                  state_in = ST_HDR;
               else if (status.req_holds)
                  state_in = ST_DATA;
               else
                  state_in = ST_PAD;
            end
         end
         ST_HDR: begin
            cmd.kind = KIND_HDR;
            cmd.emit = status.out_free;
            if (status.out_free)
               state_in = status.item_holds ? ST_DATA : ST_PAD;
         end
         ST_DATA: begin
            cmd.kind     = KIND_DATA;
            cmd.emit     = status.out_free;
            cmd.run_last = !status.fill_next_full && !status.item_last;
            if (status.out_free) begin
               if (status.fill_next_full)
                  state_in = ST_CHK;
               else if (status.item_last)
                  state_in = ST_PAD;
               else
                  state_in = ST_IDLE;
            end
         end
         ST_CHK: begin
            cmd.kind     = KIND_CHK;
            cmd.emit     = status.out_free;
            cmd.run_last = !status.item_last;
            // a closing item after an exactly full page opens a padding page
            if (status.out_free)
               state_in = status.item_last ? ST_PHDR : ST_IDLE;
         end
         ST_PHDR: begin
            // header of the padding page; the item's data beat is already out
            cmd.kind = KIND_HDR;
            cmd.emit = status.out_free;
            if (status.out_free)
               state_in = ST_PAD;
         end
         ST_PAD: begin
            cmd.kind = KIND_PAD;
            cmd.emit = status.out_free;
            if (status.out_free && status.fill_next_full)
               state_in = ST_FCHK;
         end
         ST_FCHK: begin
            cmd.kind     = KIND_FCHK;
            cmd.emit     = status.out_free;
            cmd.run_last = 1'b1;
            if (status.out_free)
               state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

endmodule

### design/prf_dpath.sv
// Datapath of the page record framer: item latch, page state, start address
// register and the output register. Depends on prf_pkg, prf_req_if, prf_rsp_if.
module prf_dpath #(
   parameter int PAGE_BYTES = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   prf_req_if.sink                     req_chan,
   prf_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [prf_pkg::ADDR_W-1:0]  csr_wdata,
   input  prf_pkg::prf_cmd_type        cmd,
   output prf_pkg::prf_status_type     status
);
   import prf_pkg::*;

   localparam logic [OFFSET_W-1:0] LAST_FILL  = OFFSET_W'(PAGE_BYTES - 2);
   localparam logic [OFFSET_W-1:0] CHK_OFFSET = OFFSET_W'(PAGE_BYTES - 1);
   localparam logic [ADDR_W-1:0]   PAGE_STEP  = ADDR_W'(PAGE_BYTES);

   logic [ADDR_W-1:0]   start_addr_ff, start_addr_in;
   logic [OFFSET_W-1:0] fill_ff, fill_in;
   logic [BYTE_W-1:0]   check_ff, check_in;
   logic [ADDR_W-1:0]   cur_addr_ff, cur_addr_in;
   logic                open_ff, open_in;

   logic [BYTE_W-1:0]   item_data_ff, item_data_in;
   logic                item_holds_ff, item_holds_in;
   logic                item_last_ff, item_last_in;

   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic [OFFSET_W-1:0] out_offset_ff, out_offset_in;
   logic [ADDR_W-1:0]   out_addr_ff, out_addr_in;
   logic                out_pend_ff, out_pend_in;
   logic                out_rend_ff, out_rend_in;
   logic                out_rlast_ff, out_rlast_in;

   logic                accept;
   logic                rec_start;
   logic [OFFSET_W-1:0] fill_inc;

   assign req_chan.ready = cmd.take;
   assign accept         = req_chan.valid && cmd.take;
   assign rec_start      = accept && (req_chan.holds_byte || req_chan.is_last) && !open_ff;
   assign fill_inc       = fill_ff + OFFSET_W'(1);

   assign status.req_valid      = req_chan.valid;
   assign status.req_holds      = req_chan.holds_byte;
   assign status.req_last       = req_chan.is_last;
   assign status.item_holds     = item_holds_ff;
   assign status.item_last      = item_last_ff;
   assign status.fill_zero      = !open_ff || (fill_ff == '0);
   assign status.fill_next_full = (fill_inc >= LAST_FILL);
   assign status.out_free       = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      start_addr_in = csr_we ? csr_wdata : start_addr_ff;
      fill_in       = fill_ff;
      check_in      = check_ff;
      cur_addr_in   = cur_addr_ff;
      open_in       = open_ff;
      item_data_in  = item_data_ff;
      item_holds_in = item_holds_ff;
      item_last_in  = item_last_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_byte_in   = out_byte_ff;
      out_offset_in = out_offset_ff;
      out_addr_in   = out_addr_ff;
      out_pend_in   = out_pend_ff;
      out_rend_in   = out_rend_ff;
      out_rlast_in  = out_rlast_ff;

      if (accept) begin
         item_data_in  = req_chan.data_byte;
         item_holds_in = req_chan.holds_byte;
         item_last_in  = req_chan.is_last;
      end
      if (rec_start) begin
         open_in     = 1'b1;
         cur_addr_in = start_addr_ff;
         fill_in     = '0;
         check_in    = '0;
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_addr_in  = cur_addr_ff;
         out_pend_in  = 1'b0;
         out_rend_in  = 1'b0;
         out_rlast_in = cmd.run_last;
         case (cmd.kind)
            KIND_HDR: begin
               out_byte_in   = HEADER_BYTE;
               out_offset_in = '0;
               check_in      = HEADER_BYTE;
            end
            KIND_DATA: begin
               out_byte_in   = item_data_ff;
               out_offset_in = fill_inc;
               check_in      = check_ff + item_data_ff;
               fill_in       = fill_inc;
            end
            KIND_PAD: begin
               out_byte_in   = '0;
               out_offset_in = fill_inc;
               fill_in       = fill_inc;
            end
            default: begin
               // page check beat; the final one also closes the record
               out_byte_in   = check_ff ^ CHECK_XOR;
               out_offset_in = CHK_OFFSET;
               out_pend_in   = 1'b1;
               out_rend_in   = (cmd.kind == KIND_FCHK);
               cur_addr_in   = cur_addr_ff + PAGE_STEP;
               fill_in       = '0;
               check_in      = '0;
               if (cmd.kind == KIND_FCHK)
                  open_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= '0;
         fill_ff       <= '0;
         check_ff      <= '0;
         cur_addr_ff   <= '0;
         open_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         start_addr_ff <= start_addr_in;
         fill_ff       <= fill_in;
         check_ff      <= check_in;
         cur_addr_ff   <= cur_addr_in;
         open_ff       <= open_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_data_ff  <= item_data_in;
      item_holds_ff <= item_holds_in;
      item_last_ff  <= item_last_in;
      out_byte_ff   <= out_byte_in;
      out_offset_ff <= out_offset_in;
      out_addr_ff   <= out_addr_in;
      out_pend_ff   <= out_pend_in;
      out_rend_ff   <= out_rend_in;
      out_rlast_ff  <= out_rlast_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.byte_offset  = out_offset_ff;
   assign rsp_chan.page_address = out_addr_ff;
   assign rsp_chan.page_end     = out_pend_ff;
   assign rsp_chan.record_end   = out_rend_ff;
   assign rsp_chan.run_last     = out_rlast_ff;

endmodule

### design/page_record_framer.sv
// Page record framer top level: sequencer plus datapath. Depends on prf_pkg,
// prf_req_if, prf_rsp_if, prf_ctrl, prf_dpath.
// The first result beat of an accepted item is loaded into the output register once the
// sequencer has left idle and that register is free. Throughput: ready only while idle,
// one beat per cycle while the output register is free; 0 to 34 beats per item.
// Reset: synchronous, active high; clears the sequencer, page state and start address.
module page_record_framer #(
   parameter int PAGE_BYTES = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   prf_req_if.sink                    req_chan,
   prf_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [prf_pkg::ADDR_W-1:0] csr_wdata
);
   import prf_pkg::*;

   prf_cmd_type    cmd;
   prf_status_type status;

   prf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   prf_dpath #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("beat loaded while output register busy");

   a_no_emit_on_take: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> !cmd.emit)
      else $error("item accepted while a beat is being produced");

   a_check_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.page_end) |->
         (rsp_chan.byte_offset == OFFSET_W'(PAGE_BYTES - 1)))
      else $error("check beat not at last page offset");

   a_record_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.record_end) |-> (rsp_chan.page_end && rsp_chan.run_last))
      else $error("record end beat is not a closing check beat");

endmodule
